>>> hw/rtl/gbk_pkg.sv
// Shared types and constants for the grid-bucketed keypoint selector.
// Used by gbk_locate, gbk_store and grid_bucketed_top_n_keypoints_unit.
`default_nettype none

package gbk_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FUNC_W     = 2;
    localparam int POS_W      = 16;
    localparam int STR_W      = 24;
    localparam int ID_W       = 16;
    localparam int BINS_W     = 5;
    localparam int KEEP_W     = 3;
    localparam int INV_W      = 16;
    localparam int CELL_W     = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_BINS_ACROSS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_DOWN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_PER_BIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_BIN_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_BIN_HEIGHT = 3'd4;

    localparam logic [BINS_W-1:0] BINS_ACROSS_RST    = 5'd8;
    localparam logic [BINS_W-1:0] BINS_DOWN_RST      = 5'd8;
    localparam logic [KEEP_W-1:0] KEEP_PER_BIN_RST   = 3'd2;
    localparam logic [INV_W-1:0]  INV_BIN_WIDTH_RST  = 16'd819;
    localparam logic [INV_W-1:0]  INV_BIN_HEIGHT_RST = 16'd1092;

    localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_OFFER = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EMIT  = 2'd2;

    typedef struct packed {
        logic [STR_W-1:0] strength;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [ID_W-1:0]  id;
    } t_slot;

    typedef struct packed {
        logic rd;
        logic wr;
        logic clr_one;
        logic clr_all;
    } t_store_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAP,
        ST_UPDATE,
        ST_SEEK
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/gbk_locate.sv
// Two-stage bin mapper: position times inverse bin size, then bin index and grid check.
// Depends on gbk_pkg.
`default_nettype none

module gbk_locate #(
    parameter int MAX_BINS = 256
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_go,
    input  wire [gbk_pkg::POS_W-1:0]     i_pos_x,
    input  wire [gbk_pkg::POS_W-1:0]     i_pos_y,
    input  wire [gbk_pkg::BINS_W-1:0]    i_bins_across,
    input  wire [gbk_pkg::BINS_W-1:0]    i_bins_down,
    input  wire [gbk_pkg::INV_W-1:0]     i_inv_w,
    input  wire [gbk_pkg::INV_W-1:0]     i_inv_h,
    output logic                         o_done,
    output logic                         o_in_grid,
    output logic [((MAX_BINS > 1) ? $clog2(MAX_BINS) : 1)-1:0] o_bin
);

    localparam int BW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int PRODW = gbk_pkg::POS_W + gbk_pkg::INV_W;
    localparam int CW    = gbk_pkg::CELL_W;
    localparam int IDXW  = CW + gbk_pkg::BINS_W;

    logic [PRODW-1:0] prod_x, prod_y;
    logic [CW-1:0]    r_col, r_row;
    logic             r_v1;
    logic [IDXW-1:0]  idx;
    logic             ok;

    assign prod_x = PRODW'(i_pos_x) * PRODW'(i_inv_w);
    assign prod_y = PRODW'(i_pos_y) * PRODW'(i_inv_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v1   <= i_go;
            o_done <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col <= prod_x[PRODW-1:PRODW-CW];
        r_row <= prod_y[PRODW-1:PRODW-CW];
    end

    always_comb begin
        idx = IDXW'(r_col) + IDXW'(i_bins_across) * IDXW'(r_row);
        ok  = (r_col < CW'(i_bins_across)) && (r_row < CW'(i_bins_down))
              && (idx < IDXW'(MAX_BINS));
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            o_in_grid <= ok;
            o_bin     <= idx[BW-1:0];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gbk_store.sv
// Bin store: one row per bin with occupied flag, fill count and sorted slots.
// Per-bin valid flops give the all-zero reset and the frame clear. Depends on gbk_pkg.
`default_nettype none

module gbk_store #(
    parameter int MAX_BINS = 256,
    parameter int MAX_KEEP = 4
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire gbk_pkg::t_store_ctl     i_ctl,
    input  wire [((MAX_BINS > 1) ? $clog2(MAX_BINS) : 1)-1:0] i_rd_addr,
    input  wire [((MAX_BINS > 1) ? $clog2(MAX_BINS) : 1)-1:0] i_wr_addr,
    input  wire [((MAX_BINS > 1) ? $clog2(MAX_BINS) : 1)-1:0] i_clr_addr,
    input  wire                          i_wr_occ,
    input  wire [$clog2(MAX_KEEP+1)-1:0] i_wr_fill,
    input  wire gbk_pkg::t_slot [MAX_KEEP-1:0] i_wr_slots,
    output logic                         o_rd_valid,
    output logic                         o_rd_occ,
    output logic [$clog2(MAX_KEEP+1)-1:0] o_rd_fill,
    output gbk_pkg::t_slot [MAX_KEEP-1:0] o_rd_slots
);

    localparam int FW    = $clog2(MAX_KEEP + 1);
    localparam int ROW_W = 1 + FW + MAX_KEEP * $bits(gbk_pkg::t_slot);

    logic [ROW_W-1:0]    mem [MAX_BINS];
    logic [ROW_W-1:0]    r_row;
    logic [MAX_BINS-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            mem[i_wr_addr] <= {i_wr_occ, i_wr_fill, i_wr_slots};
        end
        if (i_ctl.rd) begin
            r_row      <= mem[i_rd_addr];
            o_rd_valid <= r_valid[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr_all) begin
            r_valid <= '0;
        end else if (i_ctl.wr) begin
            r_valid[i_wr_addr] <= 1'b1;
        end else if (i_ctl.clr_one) begin
            r_valid[i_clr_addr] <= 1'b0;
        end
    end

    assign {o_rd_occ, o_rd_fill, o_rd_slots} = r_row;

endmodule

`default_nettype wire

>>> hw/rtl/grid_bucketed_top_n_keypoints_unit.sv
// Top level of the grid-bucketed top-N keypoint selector: control sequencer,
// configuration registers and result registers. Depends on gbk_pkg, gbk_locate, gbk_store.
//
// Usage:
//   Commands are transferred when start is high and busy is low. func selects
//   mark (bin occupied), offer (insert keypoint) or emit (next kept point).
//   Mark and offer pass through bin mapping (multiply, then index and grid
//   check), one memory read and one read-modify-write of the bin row; the
//   read and write are skipped when the point falls outside the grid, and an
//   offer to a marked bin writes nothing. They give no result.
//   Emit scans the bin store bin by bin from the cursor, until a stored point is
//   found and the next stored point is located or the last bin is reached. The
//   result sits on the o_ ports for one cycle with o_strobe high, in the cycle
//   in which busy falls. The receiver cannot stall.
//   Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_wdata) take effect at
//   once and must be made only while busy is low; the block does not enforce this.
//   Reset restores the register defaults and empties the store at once
//   through per-bin valid flags; no clearing pass is needed.
`default_nettype none

module grid_bucketed_top_n_keypoints_unit #(
    parameter int MAX_BINS = 256,
    parameter int MAX_KEEP = 4
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire [gbk_pkg::FUNC_W-1:0]        i_func,
    input  wire [gbk_pkg::POS_W-1:0]         i_pos_x,
    input  wire [gbk_pkg::POS_W-1:0]         i_pos_y,
    input  wire [gbk_pkg::STR_W-1:0]         i_strength,
    input  wire [gbk_pkg::ID_W-1:0]          i_feature_id,
    input  wire                              i_cfg_we,
    input  wire [gbk_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [gbk_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output logic                             o_strobe,
    output logic                             o_valid_res,
    output logic [gbk_pkg::POS_W-1:0]        o_out_x,
    output logic [gbk_pkg::POS_W-1:0]        o_out_y,
    output logic [gbk_pkg::STR_W-1:0]        o_out_strength,
    output logic [gbk_pkg::ID_W-1:0]         o_out_feature_id,
    output logic                             o_last
);

    localparam int BW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int FW = $clog2(MAX_KEEP + 1);
    localparam int KW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    gbk_pkg::t_state r_state, n_state;

    logic [gbk_pkg::BINS_W-1:0] r_bins_across, r_bins_down;
    logic [gbk_pkg::KEEP_W-1:0] r_keep;
    logic [gbk_pkg::INV_W-1:0]  r_inv_w, r_inv_h;

    logic [gbk_pkg::FUNC_W-1:0] r_func, n_func;
    gbk_pkg::t_slot             r_item, n_item;
    logic [BW-1:0]              r_cb, n_cb;
    logic [FW-1:0]              r_cs, n_cs;
    logic                       r_phase, n_phase;

    logic                       r_stb, n_stb;
    logic                       r_valid_res, n_valid_res;
    logic                       r_last, n_last;
    gbk_pkg::t_slot             r_out, n_out;

    logic                       accept, map_go;
    logic                       loc_done, loc_in_grid;
    logic [BW-1:0]              loc_bin;

    gbk_pkg::t_store_ctl        st_ctl;
    logic [BW-1:0]              st_rd_addr;
    logic                       st_wr_occ;
    logic [FW-1:0]              st_wr_fill;
    gbk_pkg::t_slot [MAX_KEEP-1:0] st_wr_slots;
    logic                       rd_valid, rd_occ;
    logic [FW-1:0]              rd_fill;
    gbk_pkg::t_slot [MAX_KEEP-1:0] rd_slots;

    logic [FW-1:0]              cur_fill;
    logic                       cur_occ;

    logic [FW-1:0]              cap, ins_n, ins_p, ins_top, ins_fill;
    logic                       ins_keep;
    gbk_pkg::t_slot [MAX_KEEP-1:0] ins_slots, prev_slots;

    logic [FW-1:0]              cs_inc;
    logic                       sk_found, sk_more, sk_leave, sk_at_end, sk_finish;

    assign busy   = (r_state != gbk_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign map_go = accept && (i_func == gbk_pkg::FUNC_MARK || i_func == gbk_pkg::FUNC_OFFER);

    gbk_locate #(
        .MAX_BINS (MAX_BINS)
    ) u_locate (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (map_go),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_bins_across (r_bins_across),
        .i_bins_down   (r_bins_down),
        .i_inv_w       (r_inv_w),
        .i_inv_h       (r_inv_h),
        .o_done        (loc_done),
        .o_in_grid     (loc_in_grid),
        .o_bin         (loc_bin)
    );

    gbk_store #(
        .MAX_BINS (MAX_BINS),
        .MAX_KEEP (MAX_KEEP)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (st_ctl),
        .i_rd_addr  (st_rd_addr),
        .i_wr_addr  (loc_bin),
        .i_clr_addr (r_cb),
        .i_wr_occ   (st_wr_occ),
        .i_wr_fill  (st_wr_fill),
        .i_wr_slots (st_wr_slots),
        .o_rd_valid (rd_valid),
        .o_rd_occ   (rd_occ),
        .o_rd_fill  (rd_fill),
        .o_rd_slots (rd_slots)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins_across <= gbk_pkg::BINS_ACROSS_RST;
            r_bins_down   <= gbk_pkg::BINS_DOWN_RST;
            r_keep        <= gbk_pkg::KEEP_PER_BIN_RST;
            r_inv_w       <= gbk_pkg::INV_BIN_WIDTH_RST;
            r_inv_h       <= gbk_pkg::INV_BIN_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gbk_pkg::CFG_BINS_ACROSS: begin
                    r_bins_across <= i_cfg_wdata[gbk_pkg::BINS_W-1:0];
                end
                gbk_pkg::CFG_BINS_DOWN: begin
                    r_bins_down <= i_cfg_wdata[gbk_pkg::BINS_W-1:0];
                end
                gbk_pkg::CFG_KEEP_PER_BIN: begin
                    r_keep <= i_cfg_wdata[gbk_pkg::KEEP_W-1:0];
                end
                gbk_pkg::CFG_INV_BIN_WIDTH: begin
                    r_inv_w <= i_cfg_wdata[gbk_pkg::INV_W-1:0];
                end
                gbk_pkg::CFG_INV_BIN_HEIGHT: begin
                    r_inv_h <= i_cfg_wdata[gbk_pkg::INV_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cur_fill = rd_valid ? rd_fill : '0;
    assign cur_occ  = rd_valid && rd_occ;

    // sorted insertion into one bin row
    always_comb begin
        if (r_keep == '0) begin
            cap = FW'(1);
        end else if (int'(r_keep) > MAX_KEEP) begin
            cap = FW'(MAX_KEEP);
        end else begin
            cap = FW'(r_keep);
        end
        ins_n = (cur_fill < cap) ? cur_fill : cap;
        ins_p = ins_n;
        for (int i = MAX_KEEP - 1; i >= 0; i--) begin
            if (FW'(i) < ins_n && rd_slots[i].strength < r_item.strength) begin
                ins_p = FW'(i);
            end
        end
        ins_keep = ins_p < cap;
        ins_top  = (ins_n < cap) ? ins_n : cap - FW'(1);
        ins_fill = (ins_n < cap) ? ins_n + FW'(1) : cap;
        prev_slots[0] = rd_slots[0];
        for (int i = 1; i < MAX_KEEP; i++) begin
            prev_slots[i] = rd_slots[i-1];
        end
        for (int i = 0; i < MAX_KEEP; i++) begin
            if (FW'(i) == ins_p) begin
                ins_slots[i] = r_item;
            end else if (FW'(i) > ins_p && FW'(i) <= ins_top) begin
                ins_slots[i] = prev_slots[i];
            end else begin
                ins_slots[i] = rd_slots[i];
            end
        end
    end

    // emit scan decisions
    always_comb begin
        cs_inc    = r_cs + FW'(1);
        sk_found  = r_cs < cur_fill;
        sk_more   = cs_inc < cur_fill;
        sk_leave  = !sk_found || (!r_phase && !sk_more);
        sk_at_end = (r_cb == BW'(MAX_BINS - 1));
        sk_finish = !sk_leave || sk_at_end;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gbk_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_func)
                        gbk_pkg::FUNC_MARK,
                        gbk_pkg::FUNC_OFFER: n_state = gbk_pkg::ST_MAP;
                        gbk_pkg::FUNC_EMIT:  n_state = gbk_pkg::ST_SEEK;
                        default:             n_state = gbk_pkg::ST_IDLE;
                    endcase
                end
            end
            gbk_pkg::ST_MAP: begin
                if (loc_done) begin
                    n_state = loc_in_grid ? gbk_pkg::ST_UPDATE : gbk_pkg::ST_IDLE;
                end
            end
            gbk_pkg::ST_UPDATE: begin
                n_state = gbk_pkg::ST_IDLE;
            end
            gbk_pkg::ST_SEEK: begin
                if (sk_finish) begin
                    n_state = gbk_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gbk_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_func      = r_func;
        n_item      = r_item;
        n_cb        = r_cb;
        n_cs        = r_cs;
        n_phase     = r_phase;
        n_stb       = 1'b0;
        n_valid_res = r_valid_res;
        n_last      = r_last;
        n_out       = r_out;
        st_ctl      = '0;
        st_rd_addr  = r_cb;
        st_wr_occ   = cur_occ;
        st_wr_fill  = cur_fill;
        st_wr_slots = rd_slots;
        case (r_state)
            gbk_pkg::ST_IDLE: begin
                if (accept) begin
                    n_func          = i_func;
                    n_item.strength = i_strength;
                    n_item.x        = i_pos_x;
                    n_item.y        = i_pos_y;
                    n_item.id       = i_feature_id;
                    n_phase         = 1'b0;
                    st_ctl.rd       = (i_func == gbk_pkg::FUNC_EMIT);
                end
            end
            gbk_pkg::ST_MAP: begin
                st_rd_addr = loc_bin;
                st_ctl.rd  = loc_done && loc_in_grid;
            end
            gbk_pkg::ST_UPDATE: begin
                if (r_func == gbk_pkg::FUNC_MARK) begin
                    st_ctl.wr = 1'b1;
                    st_wr_occ = 1'b1;
                end else if (!cur_occ) begin
                    st_ctl.wr = 1'b1;
                    if (ins_keep) begin
                        st_wr_fill  = ins_fill;
                        st_wr_slots = ins_slots;
                    end else begin
                        st_wr_fill = ins_n;
                    end
                end
            end
            gbk_pkg::ST_SEEK: begin
                if (!r_phase && sk_found) begin
                    n_out       = rd_slots[r_cs[KW-1:0]];
                    n_valid_res = 1'b1;
                    n_cs        = cs_inc;
                end
                if (sk_leave) begin
                    st_ctl.clr_one = 1'b1;
                    n_cs           = '0;
                    if (sk_at_end) begin
                        st_ctl.clr_all = 1'b1;
                        n_cb           = '0;
                        if (!r_phase && !sk_found) begin
                            n_out       = '0;
                            n_valid_res = 1'b0;
                        end
                    end else begin
                        n_cb       = r_cb + BW'(1);
                        n_phase    = r_phase || sk_found;
                        st_rd_addr = r_cb + BW'(1);
                        st_ctl.rd  = 1'b1;
                    end
                end
                if (sk_finish) begin
                    n_stb  = 1'b1;
                    n_last = sk_leave;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbk_pkg::ST_IDLE;
            r_cb    <= '0;
            r_cs    <= '0;
            r_phase <= 1'b0;
            r_stb   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cb    <= n_cb;
            r_cs    <= n_cs;
            r_phase <= n_phase;
            r_stb   <= n_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_item      <= n_item;
        r_valid_res <= n_valid_res;
        r_last      <= n_last;
        r_out       <= n_out;
    end

    assign o_strobe         = r_stb;
    assign o_valid_res      = r_valid_res;
    assign o_out_x          = r_out.x;
    assign o_out_y          = r_out.y;
    assign o_out_strength   = r_out.strength;
    assign o_out_feature_id = r_out.id;
    assign o_last           = r_last;

endmodule

`default_nettype wire
